// ===== hw/rtl/npt_pkg.sv =====
// npt_pkg: shared types and codes for the nearest point table match block.
// Used by npt_cell, npt_cfg and nearest_point_table_match.
package npt_pkg;

    localparam int PT_IDX_W = 10;
    localparam int PT_CNT_W = 11;

    localparam logic [1:0] OP_APPEND   = 2'd0;
    localparam logic [1:0] OP_READ     = 2'd1;
    localparam logic [1:0] OP_NEAR_THR = 2'd2;
    localparam logic [1:0] OP_NEAR     = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic                rd_mode;
        logic [15:0]         qx;
        logic [15:0]         qy;
        logic [5:0]          index;
        logic [PT_CNT_W-1:0] count;
    } t_bcast;

    typedef struct packed {
        logic                have;
        logic [32:0]         sqd;
        logic [PT_IDX_W-1:0] idx;
        logic [15:0]         x;
        logic [15:0]         y;
    } t_tok;

endpackage

// ===== hw/rtl/nearest_point_table_match.sv =====
// nearest_point_table_match: point table with append, read and nearest search.
// Instantiates npt_cfg and a row of npt_cell; depends on npt_pkg.
//
// One word at a time. An append stores its result in the result registers on
// acceptance, and these move into the output register once it is free. A read
// or either search lets a token sweep the row of cells one cell per cycle, after
// each cell registers its squared distance; the result is then registered and moved on.
// The next word is taken once the result is in the output register, even while
// that result still waits to be taken downstream.
module nearest_point_table_match import npt_pkg::*; #(
    parameter int MAX_POINTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // opcode, point_x, point_y, entry_index
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // status, found_index, found_x, found_y, entry_count
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int RUN_W = $clog2(MAX_POINTS + 2);
    localparam logic [RUN_W-1:0] RUN_LAST = RUN_W'(MAX_POINTS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [RUN_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_op, n_op;
    logic [15:0]      r_qx, n_qx;
    logic [15:0]      r_qy, n_qy;
    logic [5:0]       r_index, n_index;
    logic [CNT_W-1:0] r_count, n_count;
    logic [1:0]       r_res_st, n_res_st;
    logic [5:0]       r_res_idx, n_res_idx;
    logic [15:0]      r_res_x, n_res_x;
    logic [15:0]      r_res_y, n_res_y;
    logic [6:0]       r_res_cnt, n_res_cnt;
    logic             r_out_valid, n_out_valid;
    logic [47:0]      r_out, n_out;

    logic [1:0]  w_in_op;
    logic [15:0] w_in_x;
    logic [15:0] w_in_y;
    logic [5:0]  w_in_idx;
    logic        w_accept;
    logic        w_full;
    logic        w_wr_en;
    logic        w_hit;
    logic [31:0] w_thr_sq;
    t_bcast      w_bc;
    t_tok        w_tok [0:MAX_POINTS];

    assign w_in_op  = s_axis_tdata[1:0];
    assign w_in_x   = s_axis_tdata[17:2];
    assign w_in_y   = s_axis_tdata[33:18];
    assign w_in_idx = s_axis_tdata[39:34];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_full        = (r_count == CNT_W'(MAX_POINTS));
    assign w_wr_en       = w_accept && (w_in_op == OP_APPEND) && !w_full;

    npt_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_thr_sq (w_thr_sq)
    );

    always_comb begin
        w_bc         = '0;
        w_bc.rd_mode = (r_op == OP_READ);
        w_bc.qx      = r_qx;
        w_bc.qy      = r_qy;
        w_bc.index   = r_index;
        w_bc.count   = PT_CNT_W'(r_count);
    end

    assign w_tok[0] = '0;

    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
        npt_cell #(.ID(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr_en (w_wr_en),
            .i_wr_x  (w_in_x),
            .i_wr_y  (w_in_y),
            .i_bc    (w_bc),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    always_comb begin
        w_hit = w_tok[MAX_POINTS].have;
        if (r_op == OP_NEAR_THR && w_tok[MAX_POINTS].sqd > {1'b0, w_thr_sq}) begin
            w_hit = 1'b0;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_op        = r_op;
        n_qx        = r_qx;
        n_qy        = r_qy;
        n_index     = r_index;
        n_count     = r_count;
        n_res_st    = r_res_st;
        n_res_idx   = r_res_idx;
        n_res_x     = r_res_x;
        n_res_y     = r_res_y;
        n_res_cnt   = r_res_cnt;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out       = r_out;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op    = w_in_op;
                    n_qx    = w_in_x;
                    n_qy    = w_in_y;
                    n_index = w_in_idx;
                    n_cnt   = '0;
                    if (w_in_op == OP_APPEND) begin
                        n_state = S_HOLD;
                        if (w_full) begin
                            n_res_st  = ST_FULL;
                            n_res_idx = '0;
                            n_res_x   = '0;
                            n_res_y   = '0;
                            n_res_cnt = 7'(r_count);
                        end else begin
                            n_count   = r_count + CNT_W'(1);
                            n_res_st  = ST_OK;
                            n_res_idx = 6'(r_count);
                            n_res_x   = w_in_x;
                            n_res_y   = w_in_y;
                            n_res_cnt = 7'(n_count);
                        end
                    end else begin
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                n_cnt = r_cnt + RUN_W'(1);
                if (r_cnt == RUN_LAST) begin
                    n_state   = S_HOLD;
                    n_res_cnt = 7'(r_count);
                    if (w_hit) begin
                        n_res_st  = ST_OK;
                        n_res_idx = 6'(w_tok[MAX_POINTS].idx);
                        n_res_x   = w_tok[MAX_POINTS].x;
                        n_res_y   = w_tok[MAX_POINTS].y;
                    end else begin
                        n_res_st  = ST_MISS;
                        n_res_idx = '0;
                        n_res_x   = '0;
                        n_res_y   = '0;
                    end
                end
            end
            S_HOLD: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out       = {1'b0, r_res_cnt, r_res_y, r_res_x, r_res_idx, r_res_st};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_op        <= OP_APPEND;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_op        <= n_op;
        end
        r_qx      <= n_qx;
        r_qy      <= n_qy;
        r_index   <= n_index;
        r_res_st  <= n_res_st;
        r_res_idx <= n_res_idx;
        r_res_x   <= n_res_x;
        r_res_y   <= n_res_y;
        r_res_cnt <= n_res_cnt;
        r_out     <= n_out;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("entry count beyond table size");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out[1:0] != ST_OK) |-> (r_out[39:2] == 38'd0))
        else $error("nonzero status with nonzero entry fields");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_wr_en) |=> $stable(r_count))
        else $error("entry count changed without append");

    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_cnt <= RUN_LAST))
        else $error("sweep counter overran");

endmodule

// ===== hw/rtl/npt_cell.sv =====
// npt_cell: one table entry with its squared distance to the broadcast query.
// Passes its token (best so far, or read entry) to the next cell every cycle. Depends on npt_pkg.
module npt_cell import npt_pkg::*; #(
    parameter int ID = 0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr_en,
    input  logic [15:0] i_wr_x,
    input  logic [15:0] i_wr_y,
    input  t_bcast      i_bc,
    input  t_tok        i_tok,
    output t_tok        o_tok
);

    logic [15:0] r_x;
    logic [15:0] r_y;
    logic [32:0] r_dist;
    t_tok        r_tok;
    t_tok        n_tok;

    logic [16:0] w_dx;
    logic [16:0] w_dy;
    logic [15:0] w_ax;
    logic [15:0] w_ay;
    logic [31:0] w_sx;
    logic [31:0] w_sy;
    logic        w_live;
    logic        w_take;

    always_comb begin
        w_dx = {i_bc.qx[15], i_bc.qx} - {r_x[15], r_x};
        w_dy = {i_bc.qy[15], i_bc.qy} - {r_y[15], r_y};
        w_ax = w_dx[16] ? 16'(17'd0 - w_dx) : w_dx[15:0];
        w_ay = w_dy[16] ? 16'(17'd0 - w_dy) : w_dy[15:0];
        w_sx = w_ax * w_ax;
        w_sy = w_ay * w_ay;
    end

    always_comb begin
        w_live = i_bc.count > PT_CNT_W'(ID);
        if (i_bc.rd_mode) begin
            w_take = w_live && (PT_IDX_W'(i_bc.index) == PT_IDX_W'(ID));
        end else begin
            w_take = w_live && (!i_tok.have || (r_dist < i_tok.sqd));
        end
        n_tok = i_tok;
        if (w_take) begin
            n_tok.have = 1'b1;
            n_tok.sqd  = r_dist;
            n_tok.idx  = PT_IDX_W'(ID);
            n_tok.x    = r_x;
            n_tok.y    = r_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_bc.count == PT_CNT_W'(ID))) begin
            r_x <= i_wr_x;
            r_y <= i_wr_y;
        end
        r_dist <= 33'(w_sx) + 33'(w_sy);
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== hw/rtl/npt_cfg.sv =====
// npt_cfg: register port holding the match threshold and its square.
// Depends on npt_pkg.
module npt_cfg import npt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [31:0] o_thr_sq
);

    logic [15:0] r_thr;
    logic [31:0] r_thr_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_thr <= pwdata[15:0];
        end
        r_thr_sq <= r_thr * r_thr;
    end

    assign pready   = 1'b1;
    assign prdata   = paddr[2] ? 32'd0 : {16'd0, r_thr};
    assign o_thr_sq = r_thr_sq;

endmodule

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking bench for nearest_point_table_match (append, read, nearest search).
// Streams table ops in, checks every result word against a built-in table predictor,
// and writes the match threshold over APB between phases. Depends on npt_pkg.
module tb_top import npt_pkg::*; ();

    localparam int TABLE_DEPTH = 64;
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 16;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int PHASE_OPS = 245;
    localparam logic [2:0] ADDR_THRESHOLD = 3'd0;
    localparam logic [2:0] ADDR_UNMAPPED = 3'd4;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic [5:0]         idx;
    } t_table_op;

    typedef struct packed {
        logic [1:0]         status;
        logic [5:0]         index;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [6:0]         count;
    } t_match_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;  // opcode, point_x, point_y, entry_index
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;       // status, found_index, found_x, found_y, entry_count
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic signed [15:0] tbl_x [TABLE_DEPTH];
    logic signed [15:0] tbl_y [TABLE_DEPTH];
    int unsigned        tbl_count = 0;
    logic [15:0]        thr_model = '0;

    t_table_op          pending_ops [$];
    t_match_word        expected_words [$];
    logic signed [15:0] gen_x [$];
    logic signed [15:0] gen_y [$];
    t_table_op          sent_op;
    int                 src_idle_pct = 0;
    int                 dst_idle_pct = 0;
    int                 fail_count = 0;

    nearest_point_table_match #(.MAX_POINTS(TABLE_DEPTH)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("tb_top: FAIL");
        $finish;
    end

    function automatic t_match_word apply_table_op(t_table_op t);
        t_match_word r;
        longint      dx;
        longint      dy;
        longint      d;
        longint      best_d;
        int          best;
        r = '0;
        r.status = ST_MISS;
        case (t.op)
            OP_APPEND: begin
                if (tbl_count >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    tbl_x[tbl_count] = t.px;
                    tbl_y[tbl_count] = t.py;
                    r.status = ST_OK;
                    r.index = 6'(tbl_count);
                    r.x = t.px;
                    r.y = t.py;
                    tbl_count++;
                end
            end
            OP_READ: begin
                if (t.idx < tbl_count) begin
                    r.status = ST_OK;
                    r.index = t.idx;
                    r.x = tbl_x[t.idx];
                    r.y = tbl_y[t.idx];
                end
            end
            default: begin
                if (tbl_count > 0) begin
                    best = 0;
                    best_d = 0;
                    for (int i = 0; i < tbl_count; i++) begin
                        dx = longint'($signed(t.px)) - longint'(tbl_x[i]);
                        dy = longint'($signed(t.py)) - longint'(tbl_y[i]);
                        d = dx * dx + dy * dy;
                        if (i == 0 || d < best_d) begin
                            best_d = d;
                            best = i;
                        end
                    end
                    if (t.op == OP_NEAR || best_d <= longint'(thr_model) * longint'(thr_model))
                    begin
                        r.status = ST_OK;
                        r.index = 6'(best);
                        r.x = tbl_x[best];
                        r.y = tbl_y[best];
                    end
                end
            end
        endcase
        r.count = 7'(tbl_count);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid)
                expected_words = {expected_words, apply_table_op(sent_op)};
            if (pending_ops.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                sent_op = pending_ops.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {sent_op.idx, sent_op.py, sent_op.px, sent_op.op};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
    end

    task automatic report_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_match_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected result word, expected none actual %h",
                         $time, m_axis_tdata);
                fail_count++;
            end else begin
                want = expected_words.pop_front();
                report_field("status", 16'(want.status), 16'(m_axis_tdata[1:0]));
                report_field("found_index", 16'(want.index), 16'(m_axis_tdata[7:2]));
                report_field("found_x", want.x, m_axis_tdata[23:8]);
                report_field("found_y", want.y, m_axis_tdata[39:24]);
                report_field("entry_count", 16'(want.count), 16'(m_axis_tdata[46:40]));
                report_field("pad", 16'd0, 16'(m_axis_tdata[47]));
            end
        end
    end

    task automatic push_op(input logic [1:0] op, input int x, input int y, input int idx);
        t_table_op t;
        t.op = op;
        t.px = 16'(x);
        t.py = 16'(y);
        t.idx = 6'(idx);
        pending_ops = {pending_ops, t};
        if (op == OP_APPEND && gen_x.size() < TABLE_DEPTH) begin
            gen_x = {gen_x, t.px};
            gen_y = {gen_y, t.py};
        end
    endtask

    task automatic push_random_op();
        int pick;
        int app_w;
        int x;
        int y;
        int r;
        int base;
        pick = $urandom_range(99);
        app_w = (gen_x.size() < TABLE_DEPTH) ? 40 : 8;
        x = $urandom;
        y = $urandom;
        if (pick < app_w) begin
            case ($urandom_range(9))
                5, 6, 7: begin
                    x = int'($urandom_range(0, 1023)) - 512;
                    y = int'($urandom_range(0, 1023)) - 512;
                end
                8, 9: begin
                    if (gen_x.size() > 0) begin
                        base = $urandom_range(gen_x.size() - 1);
                        x = int'(gen_x[base]);
                        y = int'(gen_y[base]);
                    end
                end
                default: ;
            endcase
            push_op(OP_APPEND, x, y, $urandom);
        end else if (pick < app_w + 20) begin
            push_op(OP_READ, x, y, $urandom_range(63));
        end else begin
            if (gen_x.size() > 0 && $urandom_range(2) != 0) begin
                base = $urandom_range(gen_x.size() - 1);
                r = (1 << (4 * $urandom_range(4))) - 1;
                x = int'(gen_x[base]) + int'($urandom_range(0, 2 * r)) - r;
                y = int'(gen_y[base]) + int'($urandom_range(0, 2 * r)) - r;
            end
            push_op($urandom_range(1) ? OP_NEAR : OP_NEAR_THR, x, y, $urandom);
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_ops.size() != 0 || s_axis_tvalid || expected_words.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        if (!wr && prdata !== {16'd0, thr_model}) begin
            $display("%0t: threshold readback mismatch, expected %h actual %h",
                     $time, {16'd0, thr_model}, prdata);
            fail_count++;
        end
        if (wr && addr == ADDR_THRESHOLD)
            thr_model = data[15:0];
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_threshold(input logic [15:0] value);
        apb_access(1'b1, ADDR_THRESHOLD, {16'($urandom), value});
        apb_access(1'b0, ADDR_THRESHOLD, '0);
    endtask

    initial begin
        logic [15:0] thr_list [6];
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        src_idle_pct = 27;
        dst_idle_pct = 48;

        push_op(OP_NEAR, 0, 0, 0);
        push_op(OP_NEAR_THR, 0, 0, 0);
        push_op(OP_READ, 0, 0, 0);
        push_op(OP_READ, -1, -1, 63);
        push_op(OP_APPEND, 32767, 32767, 0);
        push_op(OP_APPEND, -32768, -32768, 63);
        push_op(OP_APPEND, 0, 0, 0);
        push_op(OP_APPEND, 160, 0, 0);
        push_op(OP_APPEND, -160, 0, 0);
        push_op(OP_APPEND, 0, 0, 0);
        push_op(OP_APPEND, 80, 3000, 0);
        push_op(OP_APPEND, -80, 3000, 0);
        push_op(OP_READ, 0, 0, 0);
        push_op(OP_READ, 0, 0, 7);
        push_op(OP_READ, 0, 0, 8);
        push_op(OP_READ, 0, 0, 63);
        push_op(OP_NEAR, 0, 0, 0);
        push_op(OP_NEAR, 0, 3000, 0);
        push_op(OP_NEAR, 32767, -32768, 0);
        push_op(OP_NEAR_THR, 0, 0, 0);
        push_op(OP_NEAR_THR, 1, 0, 0);
        wait_idle();

        set_threshold(16'hFFFF);
        apb_access(1'b1, ADDR_UNMAPPED, $urandom);
        apb_access(1'b0, ADDR_THRESHOLD, '0);
        push_op(OP_NEAR_THR, 32767, -32768, 0);
        push_op(OP_NEAR_THR, -32768, 32767, 0);
        wait_idle();

        set_threshold(16'd160);
        push_op(OP_NEAR_THR, 0, 160, 0);
        push_op(OP_NEAR_THR, 0, 161, 0);
        push_op(OP_NEAR_THR, 0, 3100, 0);
        wait_idle();

        thr_list[0] = 16'd0;
        thr_list[1] = 16'hFFFF;
        thr_list[2] = 16'($urandom);
        thr_list[3] = 16'($urandom_range(1, 2000));
        thr_list[4] = 16'd1;
        thr_list[5] = 16'd23170;
        for (int p = 0; p < 6; p++) begin
            set_threshold(thr_list[p]);
            src_idle_pct = (p < 2) ? 27 : (p < 4) ? 48 : 0;
            dst_idle_pct = (p < 2) ? 48 : (p < 4) ? 27 : 0;
            repeat (PHASE_OPS) push_random_op();
            wait_idle();
        end

        if (fail_count == 0 && expected_words.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/npt_pkg.sv
hw/rtl/npt_cell.sv
hw/rtl/npt_cfg.sv
hw/rtl/nearest_point_table_match.sv
tb/sv/tb_top.sv
